// File: hw/rtl/coes_pkg.sv
// Shared types, constants and helper function of the coil offset estimator.
package coes_pkg;

  localparam int CODE_W = 12;  // ADC code width
  localparam int OUT_W  = 27;  // result field width (signed fixed point)
  localparam int NUM_W  = 21;  // magnitude of the curve numerator
  localparam int DEN_W  = 19;  // curve denominator
  localparam int MAG_W  = 30;  // magnitude of the weighted filter sum

  localparam logic [CODE_W-1:0] THR_RESET = 12'd3538;

  // f(x) = (505*x - 938356) / (100*x + 60831), scaled by 2^FRAC_BITS
  localparam logic [20:0] CURVE_K = 21'd505;
  localparam logic signed [22:0] CURVE_C = 23'sd938356;
  localparam logic [18:0] DEN_K = 19'd100;
  localparam logic [18:0] DEN_C = 19'd60831;

  // Marker value for a lost line, in integer units
  localparam int LOST_INT = 999;

  // floor(m / 10) == (m * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit m
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  typedef struct packed {
    logic             neg;  // numerator sign
    logic [NUM_W-1:0] mag;  // numerator magnitude
    logic [DEN_W-1:0] den;  // denominator, always positive
  } coil_t;

  typedef struct packed {
    logic  a_below;
    logic  b_below;
    coil_t a;
    coil_t b;
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic signed [OUT_W-1:0] raw;
    logic                    lost;
  } res_t;

  // Split one ADC code into numerator sign/magnitude and denominator.
  function automatic coil_t coil_terms(logic [CODE_W-1:0] x);
    logic [20:0]        k;
    logic signed [22:0] n;
    coil_t              c;
    k = x * CURVE_K;
    n = $signed({2'b00, k}) - CURVE_C;
    c.neg = n[22];
    c.mag = n[22] ? NUM_W'(-n) : NUM_W'(n);
    c.den = DEN_W'(x * DEN_K + DEN_C);
    return c;
  endfunction

endpackage

// File: hw/rtl/coes_queue.sv
// Two-entry queue used between the front, the back and the result port.
module coes_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push_ok;
  logic         pop_ok;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/coes_div.sv
// Restoring serial divider: one quotient bit of one curve value per cycle.
module coes_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  coes_pkg::coil_t             coil,
  output logic                        busy,
  output logic signed [FRAC_BITS+4:0] quot
);
  import coes_pkg::*;

  // |num| / den < 16, so the quotient fits FRAC_BITS + 4 bits
  localparam int QW    = FRAC_BITS + 4;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [QW-1:0]    shf_r;
  logic [QW-1:0]    quo_r;
  logic             neg_r;
  logic [DEN_W+1:0] trial;
  logic             ge;

  assign busy  = busy_r;
  assign trial = {1'b0, rem_r, shf_r[QW-1]} - {2'b00, den_r};
  assign ge    = ~trial[DEN_W+1];
  assign quot  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The top part of |num| << FRAC_BITS is already below den: seed it as the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(coil.mag[NUM_W-1:4]);
      shf_r <= {coil.mag[3:0], {FRAC_BITS{1'b0}}};
      quo_r <= '0;
      den_r <= coil.den;
      neg_r <= coil.neg;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DEN_W-1:0] : DEN_W'({rem_r, shf_r[QW-1]});
      shf_r <= {shf_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/coes_front.sv
// Front end: holds the threshold, takes sample pairs, classifies them and precomputes their curve terms.
module coes_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [coes_pkg::CODE_W-1:0]   cfg_wr_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [coes_pkg::CODE_W-1:0]   in_sample_a,
  input  logic [coes_pkg::CODE_W-1:0]   in_sample_b,
  output logic                          cmd_push,
  output coes_pkg::cmd_t                cmd,
  input  logic                          cmd_full
);
  import coes_pkg::*;

  logic [CODE_W-1:0] thr_r;
  logic              valid_r, valid_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              accept;

  assign cmd_push = valid_r & ~cmd_full;
  assign in_full  = valid_r & cmd_full;
  assign accept   = in_push & ~in_full;
  assign cmd      = cmd_r;

  always_comb begin
    cmd_nxt.a_below = (in_sample_a < thr_r);
    cmd_nxt.b_below = (in_sample_b < thr_r);
    cmd_nxt.a       = coil_terms(in_sample_a);
    cmd_nxt.b       = coil_terms(in_sample_b);
    valid_nxt       = accept ? 1'b1 : (cmd_push ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: hw/rtl/coes_back.sv
// Back end: divides both curves, forms the raw offset and runs the smoothing filter.
module coes_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_empty,
  input  coes_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output coes_pkg::res_t res
);
  import coes_pkg::*;

  localparam int CW = FRAC_BITS + 5;
  localparam int RW = (FRAC_BITS + 12 > 28) ? FRAC_BITS + 12 : 28;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_COMB = 6'b000100,
    S_SUM  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic                    a_below_r, b_below_r;
  logic                    busy_a, busy_b;
  logic signed [CW-1:0]    fa, fb;
  logic signed [RW-1:0]    fa_x, fb_x, diff, diff_adj, half, lost_val, raw_w;
  logic signed [OUT_W-1:0] raw_r, raw_sat;
  logic                    lost_r;
  logic signed [OUT_W-1:0] hist_r [3];
  logic signed [31:0]      r32, h1, h2, h3, sum;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic [63:0]             prod_r;
  logic [OUT_W-1:0]        q;
  logic signed [OUT_W:0]   filt_w;
  logic signed [OUT_W-1:0] filt_sat;
  logic                    start;

  coes_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .coil  (cmd.a),
    .busy  (busy_a),
    .quot  (fa)
  );

  coes_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .coil  (cmd.b),
    .busy  (busy_b),
    .quot  (fb)
  );

  assign start    = (state_r == S_IDLE) & ~cmd_empty;
  assign cmd_pop  = start;
  assign res_push = (state_r == S_OUT) & ~res_full;

  // Combine the two curve values, truncating the half-difference toward zero
  always_comb begin
    fa_x     = RW'(fa);
    fb_x     = RW'(fb);
    diff     = fb_x - fa_x;
    diff_adj = diff + $signed({{(RW-1){1'b0}}, diff[RW-1]});
    half     = diff_adj >>> 1;
    lost_val = $signed(RW'(LOST_INT)) <<< FRAC_BITS;
    if (a_below_r && b_below_r) begin
      raw_w = half;
    end else if (b_below_r) begin
      raw_w = fb_x;
    end else if (a_below_r) begin
      raw_w = -fa_x;
    end else begin
      raw_w = lost_val;
    end
    if ((&raw_w[RW-1:OUT_W-1]) || !(|raw_w[RW-1:OUT_W-1])) begin
      raw_sat = raw_w[OUT_W-1:0];
    end else begin
      raw_sat = raw_w[RW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // 5*raw + 2*h1 + 2*h2 + h3
  always_comb begin
    r32 = 32'(raw_r);
    h1  = 32'(hist_r[0]);
    h2  = 32'(hist_r[1]);
    h3  = 32'(hist_r[2]);
    sum = (r32 <<< 2) + r32 + (h1 <<< 1) + (h2 <<< 1) + h3;
  end

  // Divide by ten via the reciprocal product, then restore the sign
  always_comb begin
    q      = prod_r[DIV10_SHIFT+OUT_W-1:DIV10_SHIFT];
    filt_w = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (filt_w[OUT_W] == filt_w[OUT_W-1]) begin
      filt_sat = filt_w[OUT_W-1:0];
    end else begin
      filt_sat = filt_w[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    res.filtered = filt_sat;
    res.raw      = raw_r;
    res.lost     = lost_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!cmd_empty) state_nxt = S_DIV;
      S_DIV:  if (!busy_a && !busy_b) state_nxt = S_COMB;
      S_COMB: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT:  if (!res_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 3; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (res_push) begin
        hist_r[2] <= hist_r[1];
        hist_r[1] <= hist_r[0];
        hist_r[0] <= raw_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_below_r <= cmd.a_below;
      b_below_r <= cmd.b_below;
    end
    if (state_r == S_COMB) begin
      raw_r  <= raw_sat;
      lost_r <= ~a_below_r & ~b_below_r;
    end
    if (state_r == S_SUM) begin
      neg_r <= sum[31];
      mag_r <= sum[31] ? MAG_W'(-sum) : MAG_W'(sum);
    end
    if (state_r == S_MUL) begin
      prod_r <= 64'({2'b00, mag_r}) * 64'(DIV10_MAGIC);
    end
  end

endmodule

// File: hw/rtl/coil_offset_estimate_and_smooth.sv
// Top level of the coil offset estimator with four-tap smoothing.
//
//   channel  ports                                        handshake
//   -------  -------------------------------------------  ------------------------
//   input    in_sample_a, in_sample_b                     in_push / in_full
//   result   out_filtered_offset, out_raw_offset, out_lost out_pop / out_empty
//   config   cfg_wr_data (threshold code)                 cfg_wr_en, no wait
//
// In the back end each request runs through the two serial dividers, which produce
// one quotient bit per cycle each, followed by the combine, sum, reciprocal multiply
// and result push steps.
// A front register and a two-entry queue hold up to three requests ahead of the
// back end; a two-entry result queue lets the back end finish while results wait.
// Synchronous active-low reset restores the threshold to 3538 and clears the history.
module coil_offset_estimate_and_smooth #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [coes_pkg::CODE_W-1:0]         cfg_wr_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [coes_pkg::CODE_W-1:0]         in_sample_a,
  input  logic [coes_pkg::CODE_W-1:0]         in_sample_b,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [coes_pkg::OUT_W-1:0]   out_filtered_offset,
  output logic signed [coes_pkg::OUT_W-1:0]   out_raw_offset,
  output logic                                out_lost
);
  import coes_pkg::*;

  // Front to back: classified requests
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;
  logic [$bits(cmd_t)-1:0] cmd_rdata;

  // Back to result port
  logic res_push, res_full;
  res_t res_in, res_out;
  logic [$bits(res_t)-1:0] res_rdata;

  // Accept pairs, classify against the threshold, precompute curve terms
  coes_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_sample_a (in_sample_a),
    .in_sample_b (in_sample_b),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  // Decouple front and back so each can stall on its own
  coes_queue #(.W($bits(cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign cmd_out = cmd_t'(cmd_rdata);

  // Divide, combine, smooth and advance the history
  coes_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Hold finished results until the consumer pops them
  coes_queue #(.W($bits(res_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_out             = res_t'(res_rdata);
  assign out_filtered_offset = res_out.filtered;
  assign out_raw_offset      = res_out.raw;
  assign out_lost            = res_out.lost;

`ifndef NO_ASSERTIONS
  // A lost line carries the positive marker value
  a_lost_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_lost) |-> !out_raw_offset[OUT_W-1])
    else $error("lost result with negative raw offset");

  // The back end never takes two requests in consecutive cycles
  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !cmd_pop)
    else $error("back end popped requests back to back");

  // The back end only pushes when the result queue has room
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");
`endif

endmodule
